[hw/rtl/adq_pkg.sv]
`default_nettype none

package adq_pkg;

	// Default capacity of the list
	localparam int DEPTH_DEF = 16;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_CLEAR      = 3'd4,
		OP_DUMP       = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/adq_ram.sv]
`default_nettype none

module adq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/array_deque.sv]
// Insert, clear, error and empty-dump results enter the output register in the cycle after
//   the item is accepted; removes and dumped elements pass the RAM read register first.
// Throughput, unless the output stalls: one item per cycle for non-reading ops; a remove
//   stalls new items until its result loads; N dumped elements stream out one per cycle.
// Reset (arst_n low, asynchronous): list empty, head at zero, output register empty;
//   the element RAM is not cleared and needs no clearing pass.
`default_nettype none

module array_deque #(
	parameter int DEPTH = adq_pkg::DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic        [adq_pkg::OP_W-1:0]     op,
	input  wire logic signed [adq_pkg::DATA_W-1:0]   value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed      [adq_pkg::DATA_W-1:0]   data,
	output logic             [adq_pkg::STATUS_W-1:0] status,
	output logic             [adq_pkg::COUNT_W-1:0]  count,
	output logic                                     last
);

	localparam int AW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

	// Two control states: take items, or stream RAM reads to the output register
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	// Ring add: base stays below DEPTH and off at most DEPTH, so one compare-subtract wraps it
	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
	                                           input logic [FW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW+1)'(off);
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		return (a == LAST_IDX) ? '0 : a + AW'(1);
	endfunction

	// Control state
	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  ptr_q;      // ring address of the next element to read
	logic [FW-1:0]  rd_idx_q;   // dump reads issued so far (fill_q on a remove); equals fill_q when the last is out
	logic           pend_q;     // RAM read data holds an element not yet loaded
	logic           out_valid_q;

	// Output register payload
	logic signed [adq_pkg::DATA_W-1:0]   data_q;
	logic        [adq_pkg::STATUS_W-1:0] status_q;
	logic        [adq_pkg::COUNT_W-1:0]  count_q;
	logic                                last_q;

	// RAM port
	logic                       we;
	logic [AW-1:0]              waddr;
	logic                       re;
	logic [AW-1:0]              raddr;
	logic [adq_pkg::DATA_W-1:0] rdata;

	logic adv;        // output register free, or emptied this cycle
	logic acc;        // item accepted
	logic is_full;
	logic is_empty;
	logic issue;      // next dump read goes out
	logic load_rd;    // RAM read data goes to the output register
	logic rd_last;

	// Decode of the accepted item
	logic                                imm_load;
	logic [adq_pkg::STATUS_W-1:0]        imm_status;
	logic [FW-1:0]                       fill_nxt;
	logic [AW-1:0]                       head_nxt;
	logic                                start_rd;
	logic [FW-1:0]                       rd_idx_start;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && adv;
	assign acc      = in_valid && in_ready;
	assign is_full  = (fill_q == FULL_FILL);
	assign is_empty = (fill_q == '0);

	assign load_rd = (state_q == ST_READ) && pend_q && adv;
	assign rd_last = (rd_idx_q == fill_q);
	assign issue   = (state_q == ST_READ) && !rd_last && (!pend_q || adv);

	// Decode the item: state update, RAM access, immediate result
	always_comb begin
		imm_load     = 1'b0;
		imm_status   = adq_pkg::STAT_OK;
		fill_nxt     = fill_q;
		head_nxt     = head_q;
		start_rd     = 1'b0;
		rd_idx_start = '0;
		we           = 1'b0;
		waddr        = ring_add(head_q, fill_q);
		re           = 1'b0;
		raddr        = ptr_q;

		if (acc) begin
			unique case (op)
				adq_pkg::OP_PUSH_FRONT: begin
					imm_load = 1'b1;
					if (is_full) begin
						imm_status = adq_pkg::STAT_FULL;
					end else begin
						head_nxt = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
						fill_nxt = fill_q + FW'(1);
						we       = 1'b1;
						waddr    = head_nxt;
					end
				end
				adq_pkg::OP_PUSH_BACK: begin
					imm_load = 1'b1;
					if (is_full) begin
						imm_status = adq_pkg::STAT_FULL;
					end else begin
						fill_nxt = fill_q + FW'(1);
						we       = 1'b1;
					end
				end
				adq_pkg::OP_POP_FRONT: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = adq_pkg::STAT_EMPTY;
					end else begin
						re           = 1'b1;
						raddr        = head_q;
						head_nxt     = ring_inc(head_q);
						fill_nxt     = fill_q - FW'(1);
						start_rd     = 1'b1;
						rd_idx_start = fill_nxt;
					end
				end
				adq_pkg::OP_POP_BACK: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = adq_pkg::STAT_EMPTY;
					end else begin
						fill_nxt     = fill_q - FW'(1);
						re           = 1'b1;
						raddr        = ring_add(head_q, fill_nxt);
						start_rd     = 1'b1;
						rd_idx_start = fill_nxt;
					end
				end
				adq_pkg::OP_CLEAR: begin
					imm_load = 1'b1;
					head_nxt = '0;
					fill_nxt = '0;
				end
				adq_pkg::OP_DUMP: begin
					if (is_empty) begin
						imm_load   = 1'b1;
						imm_status = adq_pkg::STAT_EMPTY;
					end else begin
						// Read the front element now, the rest from the READ state
						re           = 1'b1;
						raddr        = head_q;
						start_rd     = 1'b1;
						rd_idx_start = FW'(1);
					end
				end
				default: begin
					// Unused codes: drop the item, no result
				end
			endcase
		end else if (issue) begin
			re    = 1'b1;
			raddr = ptr_q;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			ptr_q       <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			head_q <= head_nxt;
			fill_q <= fill_nxt;

			unique case (state_q)
				ST_IDLE: begin
					if (start_rd) begin
						state_q  <= ST_READ;
						pend_q   <= 1'b1;
						ptr_q    <= ring_inc(head_q);
						rd_idx_q <= rd_idx_start;
					end
				end
				ST_READ: begin
					// Advance the read pointer; hold pending data until the output frees up
					if (issue) begin
						ptr_q    <= ring_inc(ptr_q);
						rd_idx_q <= rd_idx_q + FW'(1);
						pend_q   <= 1'b1;
					end else if (load_rd) begin
						pend_q <= 1'b0;
					end
					if (load_rd && rd_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (imm_load || load_rd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_rd) begin
			data_q   <= rdata;
			status_q <= adq_pkg::STAT_OK;
			count_q  <= adq_pkg::COUNT_W'(fill_q);
			last_q   <= rd_last;
		end else if (imm_load) begin
			data_q   <= '0;
			status_q <= imm_status;
			count_q  <= adq_pkg::COUNT_W'(fill_nxt);
			last_q   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign count     = count_q;
	assign last      = last_q;

	adq_ram #(
		.WIDTH (adq_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// The fill count never passes the capacity
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_FILL)
		else $error("fill count above capacity");

	// No pending read data while items are taken
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_q)
		else $error("pending read in idle state");

	// The RAM is never written while reads stream out
	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !we)
		else $error("RAM write during read streaming");

	// Never issue more reads than stored elements
	a_rd_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rd_idx_q <= fill_q))
		else $error("read index past fill count");

	// Loading the final element returns to idle
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_rd && rd_last) |=> (state_q == ST_IDLE))
		else $error("read stream did not end after last element");

endmodule

`default_nettype wire
